// File: rtl/core/acm_pkg.sv
// ----------------------------------------------------------------------------
// acm_pkg
// types, codes and gf(2^8) helpers shared by the aes chaining mode block
// ----------------------------------------------------------------------------
package acm_pkg;

  typedef logic [0:15][7:0] blk_t;

  typedef struct packed {
    logic        command;
    logic        first_block;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } acm_req_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } acm_rsp_t;

  localparam logic [3:0] REG_KEY0  = 4'd0;
  localparam logic [3:0] REG_KEY1  = 4'd1;
  localparam logic [3:0] REG_KEY2  = 4'd2;
  localparam logic [3:0] REG_KEY3  = 4'd3;
  localparam logic [3:0] REG_IV_HI = 4'd4;
  localparam logic [3:0] REG_IV_LO = 4'd5;
  localparam logic [3:0] REG_KLEN  = 4'd6;
  localparam logic [3:0] REG_MODE  = 4'd7;

  localparam logic [1:0] KLEN_128 = 2'd0;
  localparam logic [1:0] KLEN_192 = 2'd1;

  localparam logic [2:0] MODE_ECB = 3'd0;
  localparam logic [2:0] MODE_CBC = 3'd1;
  localparam logic [2:0] MODE_CFB = 3'd2;
  localparam logic [2:0] MODE_OFB = 3'd3;
  localparam logic [2:0] MODE_CTR = 3'd4;

  localparam logic [2047:0] SBOX_TBL = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

  localparam logic [2047:0] INV_SBOX_TBL = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

  function automatic logic [7:0] sbox(input logic [7:0] a);
    return SBOX_TBL[8 * (255 - a) +: 8];
  endfunction

  function automatic logic [7:0] sbox_back(input logic [7:0] a);
    return INV_SBOX_TBL[8 * (255 - a) +: 8];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic blk_t byte_subst(input blk_t s);
    blk_t t;
    for (int i = 0; i < 16; i++) t[i] = sbox(s[i]);
    return t;
  endfunction

  function automatic blk_t byte_subst_back(input blk_t s);
    blk_t t;
    for (int i = 0; i < 16; i++) t[i] = sbox_back(s[i]);
    return t;
  endfunction

  function automatic blk_t row_rotate(input blk_t s);
    blk_t t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) t[4 * c + r] = s[4 * ((c + r) % 4) + r];
    return t;
  endfunction

  function automatic blk_t row_rotate_back(input blk_t s);
    blk_t t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) t[4 * ((c + r) % 4) + r] = s[4 * c + r];
    return t;
  endfunction

  function automatic blk_t col_mix(input blk_t s);
    blk_t t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[4 * c];
      a1 = s[4 * c + 1];
      a2 = s[4 * c + 2];
      a3 = s[4 * c + 3];
      t[4 * c]     = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      t[4 * c + 1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      t[4 * c + 2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      t[4 * c + 3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    return t;
  endfunction

  function automatic logic [7:0] mul9(input logic [7:0] a);
    return xt(xt(xt(a))) ^ a;
  endfunction

  function automatic logic [7:0] mul11(input logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(a) ^ a;
  endfunction

  function automatic logic [7:0] mul13(input logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(xt(a)) ^ a;
  endfunction

  function automatic logic [7:0] mul14(input logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(xt(a)) ^ xt(a);
  endfunction

  function automatic blk_t col_mix_back(input blk_t s);
    blk_t t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[4 * c];
      a1 = s[4 * c + 1];
      a2 = s[4 * c + 2];
      a3 = s[4 * c + 3];
      t[4 * c]     = mul14(a0) ^ mul11(a1) ^ mul13(a2) ^ mul9(a3);
      t[4 * c + 1] = mul9(a0) ^ mul14(a1) ^ mul11(a2) ^ mul13(a3);
      t[4 * c + 2] = mul13(a0) ^ mul9(a1) ^ mul14(a2) ^ mul11(a3);
      t[4 * c + 3] = mul11(a0) ^ mul13(a1) ^ mul9(a2) ^ mul14(a3);
    end
    return t;
  endfunction

endpackage

// File: rtl/core/acm_ram.sv
// ----------------------------------------------------------------------------
// acm_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module acm_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/acm_round.sv
// ----------------------------------------------------------------------------
// acm_round
// one aes round, forward or inverse, with the final-round variant
// ----------------------------------------------------------------------------
module acm_round import acm_pkg::*; (
  input  blk_t st,
  input  blk_t rkey,
  input  logic dec,
  input  logic last,
  output blk_t nxt
);

  blk_t fwd_a, inv_a;

  always_comb begin
    fwd_a = row_rotate(byte_subst(st));
    if (!last) begin
      fwd_a = col_mix(fwd_a);
    end
    fwd_a = fwd_a ^ rkey;
    inv_a = byte_subst_back(row_rotate_back(st)) ^ rkey;
    if (!last) begin
      inv_a = col_mix_back(inv_a);
    end
    nxt = dec ? inv_a : fwd_a;
  end

endmodule

// File: rtl/core/aes_block_cipher_modes.sv
// ----------------------------------------------------------------------------
// aes_block_cipher_modes
// aes-128/192/256 with ecb, cbc, cfb, ofb and ctr chaining
// ----------------------------------------------------------------------------
// per request: key expansion makes 4*(Nr+1) schedule words, one a cycle,
// then each cipher pass goes through the shared round unit;
// cfb repeats the pass once per segment (four with 4-byte segments).
// rst is synchronous: clears state, config registers, chaining value and counter; the
// round key ram is not cleared, it is always rewritten before use.
module aes_block_cipher_modes import acm_pkg::*; #(
  parameter int MAX_ROUND_KEYS    = 15,
  parameter int CFB_SEGMENT_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  acm_req_t    in_req,
  output logic        out_valid,
  input  logic        out_stall,
  output acm_rsp_t    out_rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int NRW = $clog2(MAX_ROUND_KEYS);
  localparam int IW  = $clog2(4 * MAX_ROUND_KEYS);
  localparam logic [4:0] SEG    = 5'(CFB_SEGMENT_BYTES);
  localparam logic [4:0] NR_MAX = 5'(MAX_ROUND_KEYS - 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXPAND = 7'b0000010,
    S_PREP   = 7'b0000100,
    S_START  = 7'b0001000,
    S_ROUND  = 7'b0010000,
    S_POST   = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state;

  logic [63:0] kw [4];
  logic [63:0] iv_hi, iv_lo;
  logic [1:0]  key_len;
  logic [2:0]  mode;

  logic        cmd;
  blk_t        x, cv, st, res;
  logic [31:0] ctr;
  logic [4:0]  pos;
  logic [NRW-1:0] rcnt;

  logic [IW-1:0] widx;
  logic [2:0]    kcnt;
  logic [7:0]    rc;
  logic [31:0]   win [8];

  logic [3:0]     nk;
  logic [4:0]     nr_full;
  logic [NRW-1:0] nr;
  logic           is_cbc, is_cfb, is_ofb, is_ctr, dec_op;
  logic [31:0]    w_new, w_t, w_far;
  logic           ram_we;
  logic [NRW-1:0] raddr, jn;
  logic [127:0]   rdata;
  blk_t           rkey, round_nxt, blk_in;
  blk_t           ob, cv_cfb, src;
  logic [4:0]     seg_len, rem;
  logic           in_acc;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_rsp   = res;
  assign in_acc    = in_valid && !in_stall;

  assign is_cbc = (mode == MODE_CBC);
  assign is_cfb = (mode == MODE_CFB);
  assign is_ofb = (mode == MODE_OFB);
  assign is_ctr = (mode == MODE_CTR);
  assign dec_op = cmd && !is_cfb && !is_ofb && !is_ctr;

  always_comb begin
    unique case (key_len)
      KLEN_128: nk = 4'd4;
      KLEN_192: nk = 4'd6;
      default:  nk = 4'd8;
    endcase
    nr_full = 5'(nk) + 5'd6;
    nr      = NRW'((nr_full > NR_MAX) ? NR_MAX : nr_full);
  end

  // key schedule word
  always_comb begin
    case (nk)
      4'd4:    w_far = win[3];
      4'd6:    w_far = win[5];
      default: w_far = win[7];
    endcase
    w_t = win[0];
    if (kcnt == 3'd0) begin
      w_t = sub_word({win[0][23:0], win[0][31:24]}) ^ {rc, 24'h0};
    end else if (nk == 4'd8 && kcnt == 3'd4) begin
      w_t = sub_word(win[0]);
    end
    if (widx < IW'(nk)) begin
      w_new = widx[0] ? kw[widx[2:1]][31:0] : kw[widx[2:1]][63:32];
    end else begin
      w_new = w_far ^ w_t;
    end
  end

  assign ram_we = (state == S_EXPAND) && (widx[1:0] == 2'b11);

  always_comb begin
    if (state == S_PREP) begin
      jn = '0;
    end else if (state == S_START) begin
      jn = NRW'(1);
    end else begin
      jn = rcnt + NRW'(1);
    end
    raddr = dec_op ? nr - jn : jn;
  end

  acm_ram #(
    .WIDTH(128),
    .DEPTH(MAX_ROUND_KEYS)
  ) u_rk_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(widx[IW-1:2]),
    .wdata({win[2], win[1], win[0], w_new}),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rkey = blk_t'(rdata);

  acm_round u_round (
    .st  (st),
    .rkey(rkey),
    .dec (dec_op),
    .last(rcnt == nr),
    .nxt (round_nxt)
  );

  always_comb begin
    if (is_cbc && !cmd) begin
      blk_in = x ^ cv;
    end else if (is_cfb || is_ofb) begin
      blk_in = cv;
    end else if (is_ctr) begin
      blk_in = blk_t'({96'h0, ctr});
    end else begin
      blk_in = x;
    end
  end

  // cfb segment
  always_comb begin
    logic [4:0] jj;
    rem     = 5'd16 - pos;
    seg_len = (rem < SEG) ? rem : SEG;
    ob      = res;
    for (int j = 0; j < 16; j++) begin
      jj = 5'(j);
      if (jj >= pos && jj < pos + seg_len) begin
        ob[j] = x[j] ^ st[4'(jj - pos)];
      end
    end
    src = cmd ? x : ob;
    for (int j = 0; j < 16; j++) begin
      jj = 5'(j);
      if (jj < rem - seg_len + pos) begin
        cv_cfb[j] = cv[4'(jj + seg_len)];
      end else begin
        cv_cfb[j] = src[4'(pos + jj - (5'd16 - seg_len))];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      kw[0]   <= '0;
      kw[1]   <= '0;
      kw[2]   <= '0;
      kw[3]   <= '0;
      iv_hi   <= '0;
      iv_lo   <= '0;
      key_len <= '0;
      mode    <= '0;
      cv      <= '0;
      ctr     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_KEY0:  kw[0]   <= cfg_data;
          REG_KEY1:  kw[1]   <= cfg_data;
          REG_KEY2:  kw[2]   <= cfg_data;
          REG_KEY3:  kw[3]   <= cfg_data;
          REG_IV_HI: iv_hi   <= cfg_data;
          REG_IV_LO: iv_lo   <= cfg_data;
          REG_KLEN:  key_len <= cfg_data[1:0];
          REG_MODE:  mode    <= cfg_data[2:0];
          default:   ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            cmd  <= in_req.command;
            x    <= blk_t'({in_req.block_high, in_req.block_low});
            widx <= '0;
            kcnt <= '0;
            rc   <= 8'h01;
            pos  <= '0;
            if (in_req.first_block) begin
              cv  <= blk_t'({iv_hi, iv_lo});
              ctr <= '0;
            end
            state <= S_EXPAND;
          end
        end
        S_EXPAND: begin
          for (int k = 7; k > 0; k--) win[k] <= win[k - 1];
          win[0] <= w_new;
          widx   <= widx + IW'(1);
          kcnt   <= (kcnt == 3'(nk - 4'd1)) ? 3'd0 : kcnt + 3'd1;
          if (widx >= IW'(nk) && kcnt == 3'd0) begin
            rc <= xt(rc);
          end
          if (widx == {nr, 2'b11}) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          state <= S_START;
        end
        S_START: begin
          st    <= blk_in ^ rkey;
          rcnt  <= NRW'(1);
          state <= S_ROUND;
        end
        S_ROUND: begin
          st   <= round_nxt;
          rcnt <= rcnt + NRW'(1);
          if (rcnt == nr) begin
            state <= S_POST;
          end
        end
        S_POST: begin
          state <= S_OUT;
          if (is_cbc) begin
            if (cmd) begin
              res <= st ^ cv;
              cv  <= x;
            end else begin
              res <= st;
              cv  <= st;
            end
          end else if (is_cfb) begin
            res <= ob;
            cv  <= cv_cfb;
            pos <= pos + seg_len;
            if (pos + seg_len < 5'd16) begin
              state <= S_PREP;
            end
          end else if (is_ofb) begin
            res <= x ^ st;
            cv  <= st;
          end else if (is_ctr) begin
            res <= x ^ st;
            ctr <= ctr + 32'd1;
          end else begin
            res <= st;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/acm_checker.sv
// ----------------------------------------------------------------------------
// acm_checker
// port-level checks for the aes chaining mode block
// ----------------------------------------------------------------------------
module acm_checker import acm_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input acm_req_t    in_req,
  input logic        out_valid,
  input logic        out_stall,
  input acm_rsp_t    out_rsp,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [3:0]  cfg_index,
  input logic [63:0] cfg_data
);

  // one request in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepting a request");

  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("result shown while idle");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !out_valid)
    else $error("more than one result for a request");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_rsp)))
    else $error("stalled result changed");

endmodule

bind aes_block_cipher_modes acm_checker u_acm_checker (.*);

// File: dv/aes_block_cipher_modes_tb.sv
// ----------------------------------------------------------------------------
// aes_block_cipher_modes_tb
// Self-checking bench for the aes chaining mode block. A directed table covers
// the published key-length vectors, every mode, the unused mode and key length
// codes, and the first-block restart. Random phases then reprogram the key, iv,
// key length and mode and push blocks through with random gaps and stalls. Each
// result is checked against its table value or a behavioral aes model.
// ----------------------------------------------------------------------------
module aes_block_cipher_modes_tb;
  import acm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KLEN_256   = 2'd2;
  localparam logic [1:0] KLEN_SPARE = 2'd3;
  localparam logic [2:0] MODE_SPARE5 = 3'd5;
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam logic [3:0] REG_UNUSED = 4'd15;
  localparam bit CMD_ENC = 1'b0;
  localparam bit CMD_DEC = 1'b1;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 125;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  acm_req_t    in_req;
  logic        out_valid;
  logic        out_stall;
  acm_rsp_t    out_rsp;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_index;
  logic [63:0] cfg_data;

  aes_block_cipher_modes dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_rsp(out_rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // bench copy of the block state
  bit [63:0]  key_q [4];
  bit [63:0]  iv_hi_q, iv_lo_q;
  bit [1:0]   klen_q;
  bit [2:0]   mode_q;
  bit [127:0] chain_q;
  bit [31:0]  ctr_q;
  bit [31:0]  sched [60];
  int         rounds;
  bit [7:0]   sbx [256];
  bit [7:0]   isbx [256];

  acm_rsp_t   blocks_due [$];
  int         errors;
  bit         calm;
  bit         hold_req;

  function automatic bit [7:0] gmul(bit [7:0] a, bit [7:0] b);
    bit [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) r ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      b = b >> 1;
    end
    return r;
  endfunction

  function automatic bit [7:0] rol8(bit [7:0] a, int n);
    return (a << n) | (a >> (8 - n));
  endfunction

  function automatic void build_sbox();
    bit [7:0] p, r, b;
    for (int a = 0; a < 256; a++) begin
      r = 8'h01;
      p = a[7:0];
      for (int i = 1; i < 8; i++) begin
        p = gmul(p, p);
        r = gmul(r, p);
      end
      b = r;
      sbx[a] = b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ 8'h63;
    end
    for (int a = 0; a < 256; a++) isbx[sbx[a]] = a[7:0];
  endfunction

  function automatic bit [31:0] sub_w(bit [31:0] w);
    return {sbx[w[31:24]], sbx[w[23:16]], sbx[w[15:8]], sbx[w[7:0]]};
  endfunction

  function automatic void expand_schedule();
    bit [255:0] kw;
    bit [31:0]  t;
    bit [7:0]   rc;
    int         nk;
    kw = {key_q[0], key_q[1], key_q[2], key_q[3]};
    nk = (klen_q == KLEN_128) ? 4 : (klen_q == KLEN_192) ? 6 : 8;
    rounds = nk + 6;
    rc = 8'h01;
    for (int i = 0; i < nk; i++) sched[i] = kw[255 - 32 * i -: 32];
    for (int i = nk; i < 4 * (rounds + 1); i++) begin
      t = sched[i - 1];
      if (i % nk == 0) begin
        t = sub_w({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gmul(rc, 8'h02);
      end else if (nk > 6 && i % nk == 4) begin
        t = sub_w(t);
      end
      sched[i] = sched[i - nk] ^ t;
    end
  endfunction

  function automatic bit [127:0] round_key(int r);
    return {sched[4 * r], sched[4 * r + 1], sched[4 * r + 2], sched[4 * r + 3]};
  endfunction

  function automatic bit [127:0] block_cipher(bit [127:0] x, bit dec);
    bit [7:0]   s [16];
    bit [7:0]   t [16];
    bit [7:0]   m [4];
    bit [127:0] v;
    int         r;
    v = x ^ round_key(dec ? rounds : 0);
    if (dec) m = '{8'd14, 8'd11, 8'd13, 8'd9};
    else m = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int step = 1; step <= rounds; step++) begin
      r = dec ? rounds - step : step;
      for (int i = 0; i < 16; i++) s[i] = v[127 - 8 * i -: 8];
      for (int c = 0; c < 4; c++)
        for (int q = 0; q < 4; q++)
          if (dec) t[4 * ((c + q) & 3) + q] = isbx[s[4 * c + q]];
          else t[4 * c + q] = sbx[s[4 * ((c + q) & 3) + q]];
      if (dec) begin
        for (int i = 0; i < 16; i++) v[127 - 8 * i -: 8] = t[i];
        v ^= round_key(r);
        for (int i = 0; i < 16; i++) t[i] = v[127 - 8 * i -: 8];
      end
      s = t;
      if ((dec && r != 0) || (!dec && r != rounds))
        for (int c = 0; c < 4; c++)
          for (int q = 0; q < 4; q++)
            s[4 * c + q] = gmul(t[4 * c], m[(4 - q) & 3]) ^ gmul(t[4 * c + 1], m[(5 - q) & 3])
                         ^ gmul(t[4 * c + 2], m[(6 - q) & 3]) ^ gmul(t[4 * c + 3], m[(7 - q) & 3]);
      for (int i = 0; i < 16; i++) v[127 - 8 * i -: 8] = s[i];
      if (!dec) v ^= round_key(r);
    end
    return v;
  endfunction

  function automatic acm_rsp_t chain_block(acm_req_t req);
    bit [127:0] x, o, t;
    acm_rsp_t   rsp;
    expand_schedule();
    if (req.first_block) begin
      chain_q = {iv_hi_q, iv_lo_q};
      ctr_q = 32'h0;
    end
    x = {req.block_high, req.block_low};
    case (mode_q)
      MODE_CBC: begin
        if (req.command == CMD_DEC) begin
          o = block_cipher(x, 1'b1) ^ chain_q;
          chain_q = x;
        end else begin
          o = block_cipher(x ^ chain_q, 1'b0);
          chain_q = o;
        end
      end
      MODE_CFB: begin
        for (int j = 0; j < 4; j++) begin
          t = block_cipher(chain_q, 1'b0);
          o[127 - 32 * j -: 32] = x[127 - 32 * j -: 32] ^ t[127:96];
          chain_q = {chain_q[95:0],
                     (req.command == CMD_DEC) ? x[127 - 32 * j -: 32] : o[127 - 32 * j -: 32]};
        end
      end
      MODE_OFB: begin
        chain_q = block_cipher(chain_q, 1'b0);
        o = x ^ chain_q;
      end
      MODE_CTR: begin
        o = x ^ block_cipher({96'h0, ctr_q}, 1'b0);
        ctr_q = ctr_q + 32'd1;
      end
      default: o = block_cipher(x, req.command);
    endcase
    rsp.result_high = o[127:64];
    rsp.result_low = o[63:0];
    return rsp;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic bit [63:0] pick64();
    int k;
    k = $urandom_range(0, 15);
    if (k == 0) return 64'h0;
    if (k == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic int gap_len();
    int k;
    if (calm) return 0;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_reg(logic [3:0] idx, logic [63:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_KEY0: key_q[0] = val;
      REG_KEY1: key_q[1] = val;
      REG_KEY2: key_q[2] = val;
      REG_KEY3: key_q[3] = val;
      REG_IV_HI: iv_hi_q = val;
      REG_IV_LO: iv_lo_q = val;
      REG_KLEN: klen_q = val[1:0];
      REG_MODE: mode_q = val[2:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (blocks_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_block(acm_req_t req, bit known, acm_rsp_t want);
    acm_rsp_t pred;
    int       gap;
    in_req <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pred = chain_block(req);
    blocks_due.insert(blocks_due.size(), known ? want : pred);
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  typedef struct {
    bit [1:0]  klen;
    bit [2:0]  mode;
    bit        cmd;
    bit        first;
    bit [63:0] hi, lo;
    bit        known;
    bit [63:0] want_hi, want_lo;
  } vec_t;

  localparam bit [63:0] PT_HI = 64'h0011223344556677, PT_LO = 64'h8899aabbccddeeff;
  localparam bit [63:0] C128_HI = 64'h69c4e0d86a7b0430, C128_LO = 64'hd8cdb78070b4c55a;
  localparam bit [63:0] C192_HI = 64'hdda97ca4864cdfe0, C192_LO = 64'h6eaf70a0ec0d7191;
  localparam bit [63:0] C256_HI = 64'h8ea2b7ca516745bf, C256_LO = 64'heafc49904b496089;
  localparam bit [63:0] ONES = 64'hffffffffffffffff;

  vec_t vecs [] = '{
    '{KLEN_128, MODE_ECB, CMD_ENC, 1, PT_HI, PT_LO, 1, C128_HI, C128_LO},
    '{KLEN_128, MODE_ECB, CMD_DEC, 0, C128_HI, C128_LO, 1, PT_HI, PT_LO},
    '{KLEN_192, MODE_ECB, CMD_ENC, 0, PT_HI, PT_LO, 1, C192_HI, C192_LO},
    '{KLEN_192, MODE_ECB, CMD_DEC, 1, C192_HI, C192_LO, 1, PT_HI, PT_LO},
    '{KLEN_256, MODE_ECB, CMD_ENC, 0, PT_HI, PT_LO, 1, C256_HI, C256_LO},
    '{KLEN_256, MODE_ECB, CMD_DEC, 0, C256_HI, C256_LO, 1, PT_HI, PT_LO},
    '{KLEN_SPARE, MODE_ECB, CMD_ENC, 0, PT_HI, PT_LO, 1, C256_HI, C256_LO},
    '{KLEN_128, MODE_SPARE5, CMD_ENC, 0, PT_HI, PT_LO, 1, C128_HI, C128_LO},
    '{KLEN_128, MODE_SPARE6, CMD_DEC, 1, C128_HI, C128_LO, 1, PT_HI, PT_LO},
    '{KLEN_128, MODE_SPARE7, CMD_ENC, 0, 64'h0, 64'h0, 0, 64'h0, 64'h0},
    '{KLEN_128, MODE_ECB, CMD_ENC, 0, ONES, ONES, 0, 64'h0, 64'h0},
    '{KLEN_128, MODE_CBC, CMD_ENC, 1, PT_HI, PT_LO, 0, 64'h0, 64'h0},
    '{KLEN_128, MODE_CBC, CMD_ENC, 0, ONES, 64'h0, 0, 64'h0, 64'h0},
    '{KLEN_256, MODE_CBC, CMD_DEC, 1, C256_HI, C256_LO, 0, 64'h0, 64'h0},
    '{KLEN_256, MODE_CBC, CMD_DEC, 0, 64'h0, ONES, 0, 64'h0, 64'h0},
    '{KLEN_128, MODE_CFB, CMD_ENC, 1, PT_HI, PT_LO, 0, 64'h0, 64'h0},
    '{KLEN_128, MODE_CFB, CMD_ENC, 0, ONES, ONES, 0, 64'h0, 64'h0},
    '{KLEN_192, MODE_CFB, CMD_DEC, 1, C192_HI, C192_LO, 0, 64'h0, 64'h0},
    '{KLEN_192, MODE_CFB, CMD_DEC, 0, 64'h0, 64'h0, 0, 64'h0, 64'h0},
    '{KLEN_128, MODE_OFB, CMD_ENC, 1, ONES, ONES, 0, 64'h0, 64'h0},
    '{KLEN_128, MODE_OFB, CMD_DEC, 0, PT_HI, PT_LO, 0, 64'h0, 64'h0},
    '{KLEN_256, MODE_CTR, CMD_ENC, 1, PT_HI, PT_LO, 0, 64'h0, 64'h0},
    '{KLEN_256, MODE_CTR, CMD_DEC, 0, ONES, ONES, 0, 64'h0, 64'h0},
    '{KLEN_256, MODE_CTR, CMD_ENC, 0, 64'h0, 64'h0, 0, 64'h0, 64'h0}
  };

  // result side: random stalls, one long hold-off on request
  initial begin : sink
    acm_rsp_t want;
    int       hold;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (blocks_due.size() == 0) begin
          report("unexpected result high", out_rsp.result_high, 64'h0);
        end else begin
          want = blocks_due.pop_front();
          if (out_rsp.result_high !== want.result_high)
            report("result_high", out_rsp.result_high, want.result_high);
          if (out_rsp.result_low !== want.result_low)
            report("result_low", out_rsp.result_low, want.result_low);
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold = HOLD_CYCLES;
      end else if (hold == 0 && !calm && $urandom_range(0, 299) == 0) begin
        hold = $urandom_range(10, 60);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 30);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : source
    acm_req_t req;
    acm_rsp_t want;
    int       phase_mode, phase_klen;
    errors = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_req <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_KEY0;
    cfg_data <= 64'h0;
    build_sbox();
    foreach (key_q[i]) key_q[i] = 64'h0;
    iv_hi_q = 64'h0;
    iv_lo_q = 64'h0;
    klen_q = KLEN_128;
    mode_q = MODE_ECB;
    chain_q = '0;
    ctr_q = 32'h0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_KEY0, 64'h0001020304050607);
    write_reg(REG_KEY1, 64'h08090a0b0c0d0e0f);
    write_reg(REG_KEY2, 64'h1011121314151617);
    write_reg(REG_KEY3, 64'h18191a1b1c1d1e1f);
    write_reg(REG_IV_HI, 64'hf0f1f2f3f4f5f6f7);
    write_reg(REG_IV_LO, 64'hf8f9fafbfcfdfeff);
    write_reg(REG_UNUSED, ONES);
    cfg_valid <= 1'b0;

    foreach (vecs[n]) begin
      if (vecs[n].klen != klen_q || vecs[n].mode != mode_q) begin
        wait_drained();
        write_reg(REG_KLEN, {62'h0, vecs[n].klen});
        write_reg(REG_MODE, {61'h0, vecs[n].mode});
        cfg_valid <= 1'b0;
      end
      req.command = vecs[n].cmd;
      req.first_block = vecs[n].first;
      req.block_high = vecs[n].hi;
      req.block_low = vecs[n].lo;
      want.result_high = vecs[n].want_hi;
      want.result_low = vecs[n].want_lo;
      send_block(req, vecs[n].known, want);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      calm = (p == 4);
      phase_klen = p % 4;
      phase_mode = (p < 8) ? p : $urandom_range(1, 4);
      for (int k = 0; k < 4; k++)
        write_reg(REG_KEY0 + k[3:0], (p == 0) ? 64'h0 : (p == 1) ? ONES : pick64());
      write_reg(REG_IV_HI, (p == 1) ? ONES : pick64());
      write_reg(REG_IV_LO, (p == 0) ? 64'h0 : pick64());
      write_reg(REG_KLEN, {$urandom, $urandom} & ~64'h3 | phase_klen);
      write_reg(REG_MODE, {$urandom, $urandom} & ~64'h7 | phase_mode);
      cfg_valid <= 1'b0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 3 && k == 20) hold_req = 1'b1;
        req.command = $urandom_range(0, 1);
        req.first_block = (k == 0) || ($urandom_range(0, 15) == 0);
        req.block_high = pick64();
        req.block_low = pick64();
        send_block(req, 1'b0, want);
      end
    end

    in_valid <= 1'b0;
    while (blocks_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && blocks_due.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
